// ===== rtl/sdm_pkg.sv =====
`timescale 1ns / 1ps
package sdm_pkg;

   // configuration port
   localparam int CFG_DATA_W = 17;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEFT_DELAY  = 2'd0,
      CSR_RIGHT_DELAY = 2'd1,
      CSR_WET_MIX     = 2'd2
   } csr_index_type;

   // wet fraction is Q0.16; unity needs the 17th bit
   localparam int                    MIX_FRAC_BITS = 16;
   localparam logic [CFG_DATA_W-1:0] MIX_ONE       = 17'h10000;

   // control bits of one item between the ring and the mixer
   typedef struct packed {
      logic valid;
      logic wet;
      logic zero_delay;
   } stage_ctl_type;

endpackage

// ===== rtl/sdm_ifs.sv =====
`timescale 1ns / 1ps
interface sdm_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic                          channel_sel;
   logic signed [SAMPLE_BITS-1:0] in_sample;

   modport source (output valid, output channel_sel, output in_sample, input ready);
   modport sink   (input valid, input channel_sel, input in_sample, output ready);
endinterface

interface sdm_rsp_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_sample;
   logic                          wet_applied;

   modport source (output valid, output out_sample, output wet_applied, input ready);
   modport sink   (input valid, input out_sample, input wet_applied, output ready);
endinterface

interface sdm_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [sdm_pkg::CSR_IDX_W-1:0]        index;
   logic [sdm_pkg::CFG_DATA_W-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sdm_ring.sv =====
`timescale 1ns / 1ps
module sdm_ring #(
   parameter int MAX_DELAY   = 131072,
   parameter int SAMPLE_BITS = 24,
   parameter int PW          = $clog2(MAX_DELAY)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          in_channel,
   input  logic signed [SAMPLE_BITS-1:0] in_sample,
   input  logic [PW-1:0]                 left_delay,
   input  logic [PW-1:0]                 right_delay,
   output sdm_pkg::stage_ctl_type        tap_ctl,
   output logic signed [SAMPLE_BITS-1:0] tap_dry,
   output logic signed [SAMPLE_BITS-1:0] tap_delayed,
   input  logic                          tap_take
);
   import sdm_pkg::*;

   localparam int              AW       = $clog2(2 * MAX_DELAY);
   localparam logic [PW:0]     DEPTH_W  = (PW + 1)'(MAX_DELAY);
   localparam logic [PW-1:0]   LAST_POS = PW'(MAX_DELAY - 1);
   localparam logic [AW-1:0]   BANK_ONE = AW'(MAX_DELAY);

   logic signed [SAMPLE_BITS-1:0] mem [2 * MAX_DELAY];

   logic [PW-1:0]                 wp_ff [2];
   logic [PW-1:0]                 fc_ff [2];
   logic [PW-1:0]                 wp_in;
   logic [PW-1:0]                 fc_in;
   stage_ctl_type                 ctl_ff;
   logic signed [SAMPLE_BITS-1:0] dry_ff;
   logic signed [SAMPLE_BITS-1:0] rd_ff;

   logic          accept;
   logic [PW-1:0] delay;
   logic [PW-1:0] wp;
   logic [PW-1:0] fc;
   logic          wet;
   logic          zero_delay;
   logic [PW:0]   rp_wide;
   logic [AW-1:0] raddr;
   logic [AW-1:0] waddr;

   assign in_ready   = !ctl_ff.valid || tap_take;
   assign accept     = in_valid && in_ready;
   assign delay      = in_channel ? right_delay : left_delay;
   assign wp         = wp_ff[in_channel];
   assign fc         = fc_ff[in_channel];
   assign wet        = fc >= delay;
   assign zero_delay = delay == '0;

   // wrap the read position back into the channel's ring
   always_comb begin
      if (wp >= delay) begin
         rp_wide = {1'b0, wp} - {1'b0, delay};
      end else begin
         rp_wide = {1'b0, wp} + DEPTH_W - {1'b0, delay};
      end
   end

   assign raddr = (in_channel ? BANK_ONE : '0) + AW'(rp_wide[PW-1:0]);
   assign waddr = (in_channel ? BANK_ONE : '0) + AW'(wp);

   assign wp_in = (wp == LAST_POS) ? '0 : wp + 1'b1;
   assign fc_in = wet ? delay : fc + 1'b1;

   // ring memory: one write and one registered read per transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         mem[waddr] <= in_sample;
         rd_ff      <= mem[raddr];
         dry_ff     <= in_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff[0] <= '0;
         wp_ff[1] <= '0;
         fc_ff[0] <= '0;
         fc_ff[1] <= '0;
         ctl_ff   <= '0;
      end else begin
         if (accept) begin
            wp_ff[in_channel] <= wp_in;
            fc_ff[in_channel] <= fc_in;
         end
         if (in_ready) begin
            ctl_ff.valid      <= in_valid;
            ctl_ff.wet        <= wet;
            ctl_ff.zero_delay <= zero_delay;
         end
      end
   end

   assign tap_ctl     = ctl_ff;
   assign tap_dry     = dry_ff;
   assign tap_delayed = ctl_ff.zero_delay ? dry_ff : rd_ff;

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fc_ff[0] <= LAST_POS && fc_ff[1] <= LAST_POS)
      else $error("fill count beyond ring depth");

   a_no_self_read: assert property (@(posedge clock) disable iff (reset)
      accept && wet && !zero_delay |-> raddr != waddr)
      else $error("wet read collides with the write of the same transfer");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.valid && !tap_take |=> ctl_ff.valid && $stable(dry_ff) && $stable(rd_ff))
      else $error("ring output changed while stalled");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> ctl_ff.valid)
      else $error("accepted transfer lost in ring stage");

endmodule

// ===== rtl/sdm_mix.sv =====
`timescale 1ns / 1ps
module sdm_mix #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sdm_pkg::stage_ctl_type                tap_ctl,
   input  logic signed [SAMPLE_BITS-1:0]         tap_dry,
   input  logic signed [SAMPLE_BITS-1:0]         tap_delayed,
   output logic                                  tap_take,
   input  logic [sdm_pkg::CFG_DATA_W-1:0]        wet_mix,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic signed [SAMPLE_BITS-1:0]         out_sample,
   output logic                                  out_wet
);
   import sdm_pkg::*;

   localparam int PRW = SAMPLE_BITS + CFG_DATA_W + 1;
   localparam logic signed [PRW-1:0] SAT_HI = PRW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [PRW-1:0] SAT_LO = -SAT_HI - PRW'(1);

   logic                          v2_ff;
   logic                          wet2_ff;
   logic signed [SAMPLE_BITS-1:0] dry2_ff;
   logic signed [PRW-1:0]         pa_ff;
   logic signed [PRW-1:0]         pb_ff;
   logic                          v3_ff;
   logic                          wet3_ff;
   logic signed [SAMPLE_BITS-1:0] y3_ff;

   logic                          ready2;
   logic                          ready3;
   logic [CFG_DATA_W-1:0]         dry_mix;
   logic signed [PRW-1:0]         pa_in;
   logic signed [PRW-1:0]         pb_in;
   logic signed [PRW-1:0]         sum;
   logic signed [SAMPLE_BITS-1:0] y3_in;

   assign ready3   = !v3_ff || out_ready;
   assign ready2   = !v2_ff || ready3;
   assign tap_take = ready2;

   assign dry_mix = MIX_ONE - wet_mix;
   assign pa_in   = PRW'(tap_delayed) * PRW'($signed({1'b0, wet_mix}));
   assign pb_in   = PRW'(tap_dry) * PRW'($signed({1'b0, dry_mix}));

   // floor of each Q16 product, then clamp to the sample range
   assign sum = (pa_ff >>> MIX_FRAC_BITS) + (pb_ff >>> MIX_FRAC_BITS);

   always_comb begin
      if (!wet2_ff) begin
         y3_in = dry2_ff;
      end else if (sum > SAT_HI) begin
         y3_in = SAMPLE_BITS'(SAT_HI);
      end else if (sum < SAT_LO) begin
         y3_in = SAMPLE_BITS'(SAT_LO);
      end else begin
         y3_in = SAMPLE_BITS'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (ready2 && tap_ctl.valid) begin
         wet2_ff <= tap_ctl.wet;
         dry2_ff <= tap_dry;
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
      end
      if (ready3 && v2_ff) begin
         wet3_ff <= wet2_ff;
         y3_ff   <= y3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready2) begin
            v2_ff <= tap_ctl.valid;
         end
         if (ready3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   assign out_valid  = v3_ff;
   assign out_sample = y3_ff;
   assign out_wet    = wet3_ff;

   a_dry_passes: assert property (@(posedge clock) disable iff (reset)
      v2_ff && ready3 && !wet2_ff |=> y3_ff == $past(dry2_ff) && !wet3_ff)
      else $error("dry item altered by mixer");

   a_product_hold: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !ready3 |=> v2_ff && $stable(pa_ff) && $stable(pb_ff))
      else $error("product stage changed while stalled");

   a_mix_unity: assert property (@(posedge clock) disable iff (reset)
      wet_mix <= MIX_ONE)
      else $error("wet fraction above unity reached mixer");

endmodule

// ===== rtl/stereo_delay_line_mix.sv =====
`timescale 1ns / 1ps
// Stereo delay line with dry/wet mix.
//
// req_bus  : one signed sample per transfer, tagged left (0) or right (1).
// rsp_bus  : one result per request, in order: the mixed or dry sample and
//            a flag that tells whether the delayed mix was applied.
// csr_bus  : register writes (0 left delay, 1 right delay, 2 wet fraction
//            Q0.16). Always ready; write only while the block is idle.
//            Delays clamp to MAX_DELAY-1, the wet fraction to unity.
//
// Throughput is one sample per cycle while rsp_bus takes results. A request
// passes three registered stages in order: the transfer itself registers the
// ring memory read, then the two products are registered, then the sum and
// saturation go into the output register. Requests keep flowing while a
// result waits, as long as a pipeline stage is free; with all three stages
// full, ready drops until rsp_bus takes a result.
//
// Reset clears the valid flags, the configuration, the ring positions and
// the fill counts; the ring memory (2 x MAX_DELAY samples) is not cleared,
// as fill counts keep unwritten data out of results. No wait after reset.
module stereo_delay_line_mix #(
   parameter int MAX_DELAY   = 131072,
   parameter int SAMPLE_BITS = 24
) (
   input logic       clock,
   input logic       reset,
   sdm_req_if.sink   req_bus,
   sdm_rsp_if.source rsp_bus,
   sdm_csr_if.sink   csr_bus
);
   import sdm_pkg::*;

   localparam int            PW       = $clog2(MAX_DELAY);
   localparam int            CW       = (PW > CFG_DATA_W) ? PW : CFG_DATA_W;
   localparam logic [CW-1:0] LAST_W   = CW'(MAX_DELAY - 1);
   localparam logic [PW-1:0] LAST_POS = PW'(MAX_DELAY - 1);

   // configuration registers, held already clamped
   logic [PW-1:0]         left_delay_ff;
   logic [PW-1:0]         right_delay_ff;
   logic [CFG_DATA_W-1:0] wet_mix_ff;

   logic                  csr_write;
   logic [CW-1:0]         csr_data_w;
   logic [PW-1:0]         delay_in;
   logic [CFG_DATA_W-1:0] mix_in;

   stage_ctl_type                 tap_ctl;
   logic signed [SAMPLE_BITS-1:0] tap_dry;
   logic signed [SAMPLE_BITS-1:0] tap_delayed;
   logic                          tap_take;

   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;
   assign csr_data_w    = CW'(csr_bus.data);

   // clamp delay to the ring depth and the fraction to unity
   assign delay_in = (csr_data_w > LAST_W) ? LAST_POS : PW'(csr_data_w);
   assign mix_in   = (csr_bus.data > MIX_ONE) ? MIX_ONE : csr_bus.data;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_delay_ff  <= '0;
         right_delay_ff <= '0;
         wet_mix_ff     <= '0;
      end else if (csr_write) begin
         case (csr_bus.index)
            CSR_LEFT_DELAY:  left_delay_ff  <= delay_in;
            CSR_RIGHT_DELAY: right_delay_ff <= delay_in;
            CSR_WET_MIX:     wet_mix_ff     <= mix_in;
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   // ring memory, positions and fill counts
   sdm_ring #(
      .MAX_DELAY   (MAX_DELAY),
      .SAMPLE_BITS (SAMPLE_BITS),
      .PW          (PW)
   ) u_ring (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_bus.valid),
      .in_ready    (req_bus.ready),
      .in_channel  (req_bus.channel_sel),
      .in_sample   (req_bus.in_sample),
      .left_delay  (left_delay_ff),
      .right_delay (right_delay_ff),
      .tap_ctl     (tap_ctl),
      .tap_dry     (tap_dry),
      .tap_delayed (tap_delayed),
      .tap_take    (tap_take)
   );

   // products, sum, saturation and the output register
   sdm_mix #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mix (
      .clock       (clock),
      .reset       (reset),
      .tap_ctl     (tap_ctl),
      .tap_dry     (tap_dry),
      .tap_delayed (tap_delayed),
      .tap_take    (tap_take),
      .wet_mix     (wet_mix_ff),
      .out_valid   (rsp_bus.valid),
      .out_ready   (rsp_bus.ready),
      .out_sample  (rsp_bus.out_sample),
      .out_wet     (rsp_bus.wet_applied)
   );

   a_delay_clamped: assert property (@(posedge clock) disable iff (reset)
      left_delay_ff <= LAST_POS && right_delay_ff <= LAST_POS)
      else $error("delay register beyond ring depth");

   a_mix_clamped: assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_bus.index == CSR_WET_MIX |=> wet_mix_ff <= MIX_ONE)
      else $error("wet fraction register above unity");

   a_cfg_untouched: assert property (@(posedge clock) disable iff (reset)
      !csr_write |=> $stable(left_delay_ff) && $stable(right_delay_ff)
                     && $stable(wet_mix_ff))
      else $error("configuration changed without a write");

endmodule
